// ===== design/signed_int_to_decimal_ascii_core_macros.svh =====
// Assertion macros shared by the signed integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SITDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that an expression is never true outside reset.
`define SITDA_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/sitda_pkg.sv =====
// Shared constants and controller/datapath interface types for the decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH          = 8;
  localparam int DIGIT_WIDTH         = 4;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

  // Commands from the controller to the datapath; at most one is active.
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic bits_last;
    logic is_negative;
    logic top_zero;
    logic one_digit_left;
    logic out_free;
  } status_t;

endpackage

// ===== design/signed_int_to_decimal_ascii_core.sv =====
// Signed integer to decimal ASCII converter: one number in, its characters out, most significant first.
// The block takes one VALUE_WIDTH-bit two's complement number per input transaction and sends
// its decimal text one character per output transaction: a '-' for a negative value, then the
// digits with no leading zeros ('0' alone for zero), the final character flagged by last. The
// most negative value converts exactly. The shift-add BCD converter handles one magnitude bit per
// cycle, and the digit shifter then drops one leading zero or sends one character per cycle, the
// latter only while the output is not stalled. The digit capacity is 10 at 32 bits. A new number
// is accepted only once the previous one's last character sits in the output register.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [VALUE_WIDTH-1:0]    value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sitda_pkg::CHAR_WIDTH-1:0] character,
  output logic                             last
);

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t status;

  // Sequencer.
  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Conversion and output datapath.
  sitda_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule

// ===== design/sitda_datapath.sv =====
// Datapath: magnitude register, shift-add BCD converter, digit shifter and output register.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_datapath #(
  parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [VALUE_WIDTH-1:0]       value,
  input  sitda_pkg::cmd_t                     cmd,
  output sitda_pkg::status_t                  status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sitda_pkg::CHAR_WIDTH-1:0]    character,
  output logic                                last
);

  // Enough decimal digits for any magnitude up to 2^VALUE_WIDTH.
  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DW        = sitda_pkg::DIGIT_WIDTH;
  localparam int BcdW      = NumDigits * DW;
  localparam int BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [BcdW-1:0]        bcd;
  logic [BcdW-1:0]        bcd_adj;
  logic [BitCntW-1:0]     bit_count;
  logic [DigCntW-1:0]     digits_left;
  logic                   is_negative;
  logic [DW-1:0]          top_digit;
  logic                   out_free;

  // Add three to every digit of five or more before the next doubling.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*DW +: DW] = (bcd[i*DW +: DW] >= 4'd5) ? bcd[i*DW +: DW] + 4'd3
                                                      : bcd[i*DW +: DW];
    end
  end

  assign top_digit = bcd[BcdW-1 -: DW];
  assign out_free  = !out_valid || !out_stall;

  // Status toward the controller.
  always_comb begin
    status.bits_last      = (bit_count == BitCntW'(1));
    status.is_negative    = is_negative;
    status.top_zero       = (top_digit == '0);
    status.one_digit_left = (digits_left == DigCntW'(1));
    status.out_free       = out_free;
  end

  // Conversion registers: load the magnitude, shift it bit by bit into the BCD digits, then shift the digits out.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_negative <= value[VALUE_WIDTH-1];
      mag         <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
      bcd         <= '0;
      bit_count   <= BitCntW'(VALUE_WIDTH);
      digits_left <= DigCntW'(NumDigits);
    end else if (cmd.dabble) begin
      bcd       <= {bcd_adj[BcdW-2:0], mag[VALUE_WIDTH-1]};
      mag       <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bit_count <= bit_count - BitCntW'(1);
    end else if (cmd.shift_digit || cmd.emit_digit) begin
      bcd         <= {bcd[BcdW-DW-1:0], {DW{1'b0}}};
      digits_left <= digits_left - DigCntW'(1);
    end
  end

  // Output register: holds one character transaction until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= sitda_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_WIDTH'(top_digit);
      last      <= (digits_left == DigCntW'(1));
    end
  end

  // A character is never written over one that is still stalled.
  `SITDA_NEVER(a_no_overwrite, (cmd.emit_sign || cmd.emit_digit) && !out_free, "character overwritten while stalled")
  // Conversion steps only run while magnitude bits remain.
  `SITDA_ASSERT(a_dabble_bits, cmd.dabble |-> (bit_count != '0), "conversion step with no bits left")
  // A digit is only shifted or sent while digits remain.
  `SITDA_ASSERT(a_digit_left, (cmd.shift_digit || cmd.emit_digit) |-> (digits_left != '0), "digit shifted with none left")
  // The controller issues one command at a time.
  `SITDA_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.dabble, cmd.shift_digit, cmd.emit_sign, cmd.emit_digit}), "conflicting datapath commands")

endmodule

// ===== design/sitda_ctrl.sv =====
// Controller state machine sequencing load, conversion, sign, zero skipping and digit output.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sitda_pkg::status_t status,
  output sitda_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CONVERT = 5'b00010,
    ST_SIGN    = 5'b00100,
    ST_SKIP    = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.dabble = 1'b1;
        if (status.bits_last) begin
          state_next = status.is_negative ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the final digit.
        if (status.top_zero && !status.one_digit_left) begin
          cmd.shift_digit = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.one_digit_left) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sending the final digit returns the controller to idle.
  `SITDA_ASSERT(a_done_idle, (state == ST_EMIT && status.out_free && status.one_digit_left) |=> (state == ST_IDLE), "no return to idle after final digit")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_WIDTH   = 32;
  localparam int RANDOM_ITEMS  = 360;
  localparam int PHASES        = 4;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 100;

  // Expected characters of every accepted number, oldest first, and the checks against them.
  class text_scoreboard;
    logic [sitda_pkg::CHAR_WIDTH-1:0] exp_char[$];
    bit                               exp_last[$];
    int                               fails;

    function new();
      fails = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fails++;
    endtask

    // Works out the decimal text of an accepted number and queues its characters.
    function void note_value(input logic [VALUE_WIDTH-1:0] num);
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [3:0]             digits [0:19];
      int                     count;
      negative = num[VALUE_WIDTH-1];
      // Two's complement negation in unsigned terms also covers the most negative value.
      magnitude = negative ? (~num + 1'b1) : num;
      count = 0;
      do begin
        digits[count] = 4'(magnitude % 10);
        count++;
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (negative) begin
        exp_char.push_back(sitda_pkg::CHAR_MINUS);
        exp_last.push_back(1'b0);
      end
      for (int i = count - 1; i >= 0; i--) begin
        exp_char.push_back(sitda_pkg::CHAR_ZERO + digits[i]);
        exp_last.push_back(i == 0);
      end
    endfunction

    // Compares one received character with the oldest expectation.
    task check_char(input logic [sitda_pkg::CHAR_WIDTH-1:0] ch, input logic lst);
      logic [sitda_pkg::CHAR_WIDTH-1:0] want_char;
      bit                               want_last;
      if (exp_char.size() == 0) begin
        report($sformatf("unexpected character %h last %b", ch, lst));
      end else begin
        want_char = exp_char.pop_front();
        want_last = exp_last.pop_front();
        if (ch !== want_char)
          report($sformatf("character %h, expected %h", ch, want_char));
        if (lst !== want_last)
          report($sformatf("last %b on character %h, expected %b", lst, ch, want_last));
      end
    endtask

    function int pending();
      return exp_char.size();
    endfunction
  endclass

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_stall;
  logic signed [VALUE_WIDTH-1:0]    value     = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [sitda_pkg::CHAR_WIDTH-1:0] character;
  logic                             last;

  text_scoreboard sb = new();

  // Percent of cycles idle per phase: none, sender, receiver, both.
  int send_idle_pct [PHASES] = '{0, 67, 0, 14};
  int recv_stall_pct[PHASES] = '{0, 0, 67, 14};
  int send_pct = 0;
  int recv_pct = 0;

  signed_int_to_decimal_ascii_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .character(character),
    .last     (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one number, idling at random first, and waits until it is taken.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] num);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_value(num);
  endtask

  // Draws a number: fully random, at most a given digit count, near a power of ten, or near the extremes.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] span;
    logic [VALUE_WIDTH-1:0] num;
    int unsigned            digit_count;
    span = 1;
    digit_count = $urandom_range(9, 1);
    repeat (digit_count) span = span * 10;
    case ($urandom_range(3, 0))
      0: num = $urandom;
      1: num = $urandom_range(span - 1, 0);
      2: num = span + $urandom_range(2, 0) - 1;
      default: begin
        if ($urandom_range(1, 0))
          num = 32'h7FFF_FFFF - $urandom_range(3, 0);
        else
          num = 32'h8000_0000 + $urandom_range(3, 0);
      end
    endcase
    if ($urandom_range(1, 0)) num = -num;
    return num;
  endfunction

  // Receiver: checks each accepted character, then decides whether to stall next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(character, last);
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // Main sequence: reset, directed numbers, random phases, drain and verdict.
  initial begin
    int drain_cycles;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Zero, single digits, powers of ten and their neighbors, extremes, bit patterns.
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd9);
    send_value(32'sd10);
    send_value(-32'sd10);
    send_value(32'sd99);
    send_value(32'sd100);
    send_value(-32'sd7);
    send_value(32'sd42);
    send_value(32'sd2147483647);
    send_value(32'h8000_0000);
    send_value(-32'sd2147483647);
    send_value(32'sd1000000000);
    send_value(32'sd999999999);
    send_value(-32'sd999999999);
    send_value(32'sd1000000001);
    send_value(32'sd123456789);
    send_value(-32'sd123456789);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);

    for (int p = 0; p < PHASES; p++) begin
      send_pct = send_idle_pct[p];
      recv_pct = recv_stall_pct[p];
      repeat (RANDOM_ITEMS / PHASES) send_value(pick_value());
    end
    in_valid <= 1'b0;

    // Wait for every queued character, then give the block time to misbehave.
    drain_cycles = 0;
    while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("signed_int_to_decimal_ascii_core regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii_core regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000;
    $display("signed_int_to_decimal_ascii_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sitda_pkg.sv
design/sitda_datapath.sv
design/sitda_ctrl.sv
design/signed_int_to_decimal_ascii_core.sv
sim/tb_top.sv
